// File: rtl/base64_codec_unit_defines.svh
// Assertion macros for the checker file of the Base64 codec.
// Depends on nothing; included by name where assertions are written.
`ifndef BASE64_CODEC_UNIT_DEFINES_SVH
`define BASE64_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64C_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64C_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/b64c_pkg.sv
// Shared types, constants and alphabet functions for the Base64 codec.
// Used by every module of the codec; depends on nothing.
package b64c_pkg;

	// Pad character of the alphabet.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Configuration port layout.
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_DECODE_MODE = 1'b0;

	// Group queue between front and back.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// What the back end must do with a queued group.
	typedef enum logic [1:0] {
		KIND_ENC  = 2'd0,
		KIND_DEC  = 2'd1,
		KIND_PART = 2'd2
	} kind_t;

	// One finished group as handed from front to back.
	typedef struct packed {
		logic [23:0] bits;    // collected bytes or 6-bit values, from bit 23 down
		kind_t       kind;
		logic [1:0]  cnt;     // encode: number of bytes collected (1 to 3)
		logic [1:0]  pad;     // decode: bit 0 third char was pad, bit 1 fourth
		logic        last;    // group closed by the end of the stream
	} grp_t;

	// Character to its 6-bit value; anything outside the alphabet is zero.
	function automatic logic [5:0] char_value(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
			else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
			else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
			else if (c == 8'h2B) v = 8'd62;
			else if (c == 8'h2F) v = 8'd63;
			return v[5:0];
		end
	endfunction

	// 6-bit value to its alphabet character.
	function automatic logic [7:0] sixbit_to_char(input logic [5:0] s);
		logic [7:0] v;
		begin
			v = {2'b00, s};
			if (s < 6'd26) return v + 8'h41;
			else if (s < 6'd52) return v - 8'd26 + 8'h61;
			else if (s < 6'd62) return v - 8'd52 + 8'h30;
			else if (s == 6'd62) return 8'h2B;
			else return 8'h2F;
		end
	endfunction

endpackage

// File: rtl/b64c_front.sv
// Front end of the Base64 codec: accepts input bytes and collects groups.
// Depends on b64c_pkg; feeds finished groups into b64c_queue.
module b64c_front
	import b64c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        decode_mode,
	input  logic        cfg_clear,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_data,
	input  logic        in_end,
	input  logic        q_full,
	output logic        push,
	output grp_t        push_entry
);

	logic [23:0] bits_q;
	logic [1:0]  count_q;
	logic [1:0]  pad_q;

	logic        accept;
	logic [23:0] enc_bits;
	logic [23:0] dec_bits;
	logic [5:0]  val;
	logic [1:0]  dec_pad;
	logic [1:0]  enc_cnt;
	logic        close;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign val      = char_value(in_data);
	assign enc_cnt  = count_q + 2'd1;

	// Merge the incoming item into the group at its position.
	always_comb begin
		case (count_q)
			2'd0:    enc_bits = bits_q | {in_data, 16'h0000};
			2'd1:    enc_bits = bits_q | {8'h00, in_data, 8'h00};
			default: enc_bits = bits_q | {16'h0000, in_data};
		endcase
		case (count_q)
			2'd0:    dec_bits = bits_q | {val, 18'd0};
			2'd1:    dec_bits = bits_q | {6'd0, val, 12'd0};
			2'd2:    dec_bits = bits_q | {12'd0, val, 6'd0};
			default: dec_bits = bits_q | {18'd0, val};
		endcase
		dec_pad = pad_q;
		if (count_q == 2'd2 && in_data == PAD_CHAR) dec_pad[0] = 1'b1;
		if (count_q == 2'd3 && in_data == PAD_CHAR) dec_pad[1] = 1'b1;
	end

	// Decide whether this item closes a group, and what kind of group it is.
	always_comb begin
		push_entry.bits = decode_mode ? dec_bits : enc_bits;
		push_entry.cnt  = enc_cnt;
		push_entry.pad  = dec_pad;
		push_entry.last = in_end;
		if (decode_mode) begin
			close           = in_end || (count_q == 2'd3);
			push_entry.kind = (count_q == 2'd3) ? KIND_DEC : KIND_PART;
		end else begin
			close           = in_end || (count_q == 2'd2);
			push_entry.kind = KIND_ENC;
		end
		push = accept && close;
	end

	// Group state: cleared by a mode write or when a group closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= 24'd0;
			count_q <= 2'd0;
			pad_q   <= 2'd0;
		end else if (cfg_clear || push) begin
			bits_q  <= 24'd0;
			count_q <= 2'd0;
			pad_q   <= 2'd0;
		end else if (accept) begin
			bits_q  <= decode_mode ? dec_bits : enc_bits;
			count_q <= enc_cnt;
			pad_q   <= decode_mode ? dec_pad : 2'd0;
		end
	end

endmodule

// File: rtl/b64c_queue.sv
// Short FIFO of finished groups between front and back of the codec.
// Depends on b64c_pkg for the entry type and depth.
module b64c_queue
	import b64c_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  grp_t  push_entry,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output grp_t  head_entry
);

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/b64c_back.sv
// Back end of the Base64 codec: expands a queued group into result bytes.
// Depends on b64c_pkg; drives the output register of the codec.
module b64c_back
	import b64c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  grp_t        head_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        stream_done,
	output logic        partial_group
);

	logic [1:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       stream_done_q;
	logic       partial_q;

	logic       advance;
	logic [1:0] last_step;
	logic       is_last;
	logic [5:0] sixbit;
	logic [7:0] res_byte;

	assign advance = !out_valid_q || out_ready;

	// Index of the last result for this group, and the result at the current step.
	always_comb begin
		case (head_entry.kind)
			KIND_ENC: last_step = 2'd3;
			KIND_DEC: last_step = 2'd2 - {1'b0, head_entry.pad[0]} - {1'b0, head_entry.pad[1]};
			default:  last_step = 2'd0;
		endcase
		is_last = (step_q == last_step);

		case (step_q)
			2'd0:    sixbit = head_entry.bits[23:18];
			2'd1:    sixbit = head_entry.bits[17:12];
			2'd2:    sixbit = head_entry.bits[11:6];
			default: sixbit = head_entry.bits[5:0];
		endcase

		case (head_entry.kind)
			KIND_ENC: begin
				res_byte = sixbit_to_char(sixbit);
				if (step_q == 2'd2 && head_entry.cnt < 2'd2) res_byte = PAD_CHAR;
				if (step_q == 2'd3 && head_entry.cnt < 2'd3) res_byte = PAD_CHAR;
			end
			KIND_DEC: begin
				case (step_q)
					2'd0:    res_byte = head_entry.bits[23:16];
					2'd1:    res_byte = head_entry.pad[0] ? head_entry.bits[7:0]
					                                      : head_entry.bits[15:8];
					default: res_byte = head_entry.bits[7:0];
				endcase
			end
			default: res_byte = 8'h00;
		endcase

		pop = head_valid && advance && is_last;
	end

	// Step counter through the results of the head group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= is_last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_byte_q    <= res_byte;
			run_last_q    <= is_last;
			stream_done_q <= is_last && head_entry.last;
			partial_q     <= (head_entry.kind == KIND_PART);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign run_last      = run_last_q;
	assign stream_done   = stream_done_q;
	assign partial_group = partial_q;

endmodule

// File: rtl/base64_codec_unit.sv
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
//
//   Channel      Direction  Carries
//   s_axis       in         tdata[7:0] data_byte, tlast stream_end
//   m_axis       out        tdata[7:0] out_byte, tlast stream_done,
//                           tuser[0] run_last, tuser[1] partial_group
//   APB          in/out     decode_mode at byte address 0
//
// One input byte is taken per cycle while the group queue has room; the back end
// emits one result per cycle while not stalled, so an encode stream gives four
// results per three input bytes. A group's first result is offered once its
// closing item has passed the group queue and the output register. Reset clears
// group state, queue pointers and output valid; decode_mode resets to encode. A
// stalled output fills the two-entry queue, after which s_axis_tready drops.
module base64_codec_unit
	import b64c_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
	output logic                  m_axis_tlast,
	output logic [1:0]            m_axis_tuser,   // [0] run_last, [1] partial_group
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic  mode_q;
	logic  cfg_wr;
	logic  cfg_clear;
	logic  q_full;
	logic  push;
	grp_t  push_entry;
	logic  pop;
	logic  head_valid;
	grp_t  head_entry;
	logic  run_last;
	logic  partial_group;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_clear = cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_DECODE_MODE);
	assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_DECODE_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_clear) begin
			mode_q <= pwdata[0];
		end
	end

	// Front end: collects groups.
	b64c_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.decode_mode(mode_q),
		.cfg_clear  (cfg_clear),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_end     (s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Group queue.
	b64c_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back end: emits results.
	b64c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.run_last     (run_last),
		.stream_done  (m_axis_tlast),
		.partial_group(partial_group)
	);

	assign m_axis_tuser = {partial_group, run_last};

endmodule

// File: rtl/b64c_checker.sv
// Port-level assertions for the Base64 codec, bound to its top level.
// Depends on b64c_pkg and base64_codec_unit_defines.svh.
`include "base64_codec_unit_defines.svh"

module b64c_checker
	import b64c_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [1:0] m_axis_tuser
);

	// A stalled result keeps its valid and payload.
	`B64C_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed while stalled")

	// A dropped partial group shows as a single zero result that ends the stream.
	`B64C_ASSERT_NOW(a_partial_form, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == 8'h00), "malformed partial-group result")

	// The end of a stream is always the last result of its input.
	`B64C_ASSERT_NOW(a_done_is_last, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "stream end without run end")

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (.*);
